@@ hdl/mrtu_pkg.sv @@
// Shared types, constants and CRC function for the Modbus RTU request decoder.
`timescale 1ns / 1ps
`default_nettype none

package mrtu_pkg;

   localparam int MAX_FRAME = 128;
   localparam int MIN_FRAME = 8;
   localparam int HDR_BYTES = 6;
   localparam int CNT_W     = $clog2(MAX_FRAME + 2);

   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam logic [15:0] COIL_ON_VALUE = 16'hFF00;
   localparam logic [7:0]  UNIT_ID_RESET = 8'd1;

   localparam logic [7:0] FC_COIL_STATUS    = 8'd1;
   localparam logic [7:0] FC_READ_DISCRETE  = 8'd2;
   localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
   localparam logic [7:0] FC_READ_INPUT     = 8'd4;
   localparam logic [7:0] FC_FORCE_COIL     = 8'd5;
   localparam logic [7:0] FC_WRITE_REGS     = 8'd16;

   typedef enum logic [2:0] {
      ST_ACCEPTED      = 3'd0,
      ST_SHORT         = 3'd1,
      ST_OTHER_UNIT    = 3'd2,
      ST_BAD_CRC       = 3'd3,
      ST_UNKNOWN_FC    = 3'd4,
      ST_QTY_TOO_LARGE = 3'd5,
      ST_WRONG_LENGTH  = 3'd6,
      ST_OVERFLOW      = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      CMD_READ_BITS  = 2'd0,
      CMD_READ_REGS  = 2'd1,
      CMD_WRITE_COIL = 2'd2,
      CMD_WRITE_REGS = 2'd3
   } command_type;

   // frame state captured on the last byte
   typedef struct packed {
      logic                           ovf;
      logic [CNT_W-1:0]               count;
      logic [15:0]                    crc;
      logic [15:0]                    rx_crc;
      logic [HDR_BYTES-1:0][7:0]      hdr;
   } snap_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ hdl/mrtu_frame_acc.sv @@
// Per-byte frame state: running CRC, byte count, header, delay line, snapshot.
`timescale 1ns / 1ps
`default_nettype none

module mrtu_frame_acc (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        rx_byte,
   input  wire logic              frame_end,
   input  wire logic              snap_take,
   output logic                   snap_valid,
   output mrtu_pkg::snap_type     snap
);
   import mrtu_pkg::*;

   logic [15:0]               crc_ff, crc_in, crc_upd;
   logic [CNT_W-1:0]          count_ff, count_in, count_upd;
   logic                      ovf_ff, ovf_in, ovf_upd;
   logic [7:0]                d0_ff, d0_in, d1_ff, d1_in;
   logic [HDR_BYTES-1:0][7:0] hdr_ff, hdr_in;
   logic                      snap_valid_ff, snap_valid_in;
   snap_type                  snap_ff, snap_in;

   always_comb begin
      crc_upd   = (count_ff >= CNT_W'(2)) ? crc_byte(crc_ff, d0_ff) : crc_ff;
      count_upd = (count_ff < CNT_W'(MAX_FRAME + 1)) ? count_ff + CNT_W'(1) : count_ff;
      ovf_upd   = ovf_ff | (count_upd > CNT_W'(MAX_FRAME));
      hdr_in    = hdr_ff;
      if (accept) begin
         for (int i = 0; i < HDR_BYTES; i++) begin
            if (count_ff == CNT_W'(i)) begin
               hdr_in[i] = rx_byte;
            end
         end
      end

      crc_in   = crc_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      d0_in    = d0_ff;
      d1_in    = d1_ff;
      snap_in  = snap_ff;
      snap_valid_in = snap_valid_ff & ~snap_take;
      if (accept) begin
         if (frame_end) begin
            crc_in   = CRC_INIT;
            count_in = '0;
            ovf_in   = 1'b0;
            d0_in    = 8'h00;
            d1_in    = 8'h00;
            snap_in.ovf    = ovf_upd;
            snap_in.count  = count_upd;
            snap_in.crc    = crc_upd;
            snap_in.rx_crc = {rx_byte, d1_ff};
            snap_in.hdr    = hdr_in;
            snap_valid_in  = 1'b1;
         end else begin
            crc_in   = crc_upd;
            count_in = count_upd;
            ovf_in   = ovf_upd;
            d0_in    = d1_ff;
            d1_in    = rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff        <= CRC_INIT;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         d0_ff         <= 8'h00;
         d1_ff         <= 8'h00;
         snap_valid_ff <= 1'b0;
      end else begin
         crc_ff        <= crc_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         d0_ff         <= d0_in;
         d1_ff         <= d1_in;
         snap_valid_ff <= snap_valid_in;
      end
      hdr_ff  <= hdr_in;
      snap_ff <= snap_in;
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

   a_snap_held: assert property (@(posedge clock) disable iff (reset)
      snap_valid_ff && !snap_take |=> snap_valid_ff)
      else $error("pending frame snapshot dropped");

   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_FRAME + 1))
      else $error("byte count beyond saturation");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      accept && frame_end |=> count_ff == '0 && crc_ff == CRC_INIT && !ovf_ff)
      else $error("frame state not cleared after last byte");

endmodule

`default_nettype wire

@@ hdl/mrtu_check.sv @@
// Request checks and reply sizing on the frame snapshot, with the result register.
`timescale 1ns / 1ps
`default_nettype none

module mrtu_check (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              snap_valid,
   input  wire mrtu_pkg::snap_type snap,
   input  wire logic [7:0]        unit_id,
   output logic                   snap_take,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [2:0]             rsp_status,
   output logic [1:0]             rsp_command,
   output logic [7:0]             rsp_function_code,
   output logic [15:0]            rsp_start_address,
   output logic [15:0]            rsp_quantity,
   output logic                   rsp_coil_on,
   output logic [7:0]             rsp_reply_byte_count,
   output logic [8:0]             rsp_reply_length
);
   import mrtu_pkg::*;

   logic [7:0]  fc;
   logic [15:0] addr, qty, bits;
   logic [16:0] regs2;
   logic        known, len_bad;
   status_type  st;
   command_type cmd;
   logic        coil;
   logic [7:0]  rbc;
   logic [8:0]  rlen;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  status_ff;
   command_type command_ff;
   logic [7:0]  fc_ff, rbc_ff;
   logic [15:0] addr_ff, qty_ff;
   logic        coil_ff;
   logic [8:0]  rlen_ff;

   always_comb begin
      fc    = snap.hdr[1];
      addr  = {snap.hdr[2], snap.hdr[3]};
      qty   = {snap.hdr[4], snap.hdr[5]};
      known = 1'b1;
      cmd   = CMD_READ_BITS;
      coil  = 1'b0;
      case (fc)
         FC_COIL_STATUS, FC_READ_DISCRETE: cmd = CMD_READ_BITS;
         FC_READ_HOLDING, FC_READ_INPUT:  cmd = CMD_READ_REGS;
         FC_FORCE_COIL: begin
            cmd  = CMD_WRITE_COIL;
            coil = (qty == COIL_ON_VALUE);
         end
         FC_WRITE_REGS: cmd = CMD_WRITE_REGS;
         default:       known = 1'b0;
      endcase

      len_bad = (fc == FC_WRITE_REGS)
              ? (18'(snap.count) != 18'd9 + {1'b0, qty, 1'b0})
              : (snap.count != CNT_W'(MIN_FRAME));

      if (snap.ovf)                                     st = ST_OVERFLOW;
      else if (snap.count < CNT_W'(MIN_FRAME))          st = ST_SHORT;
      else if (snap.hdr[0] != unit_id)                  st = ST_OTHER_UNIT;
      else if (snap.crc != snap.rx_crc)                 st = ST_BAD_CRC;
      else if (!known)                                  st = ST_UNKNOWN_FC;
      else if (fc != FC_FORCE_COIL && qty > 16'(MAX_FRAME)) st = ST_QTY_TOO_LARGE;
      else if (len_bad)                                 st = ST_WRONG_LENGTH;
      else                                              st = ST_ACCEPTED;

      bits  = (qty == 16'd0) ? 16'd1 : ((qty - 16'd1) >> 3) + 16'd1;
      regs2 = {qty, 1'b0};
      rbc   = 8'h00;
      rlen  = 9'd0;
      if (st == ST_ACCEPTED) begin
         case (cmd)
            CMD_READ_BITS: begin
               rbc  = bits[7:0];
               rlen = 9'(bits + 16'd5);
            end
            CMD_READ_REGS: begin
               rbc  = regs2[7:0];
               rlen = 9'(regs2 + 17'd5);
            end
            default: begin
               rbc  = 8'h00;
               rlen = 9'd8;
            end
         endcase
      end

      if (st inside {ST_OVERFLOW, ST_SHORT}) begin
         cmd  = CMD_READ_BITS;
         coil = 1'b0;
         fc   = 8'h00;
         addr = 16'h0000;
         qty  = 16'h0000;
      end
   end

   assign snap_take    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = snap_take ? snap_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (snap_take && snap_valid) begin
         status_ff  <= st;
         command_ff <= cmd;
         fc_ff      <= fc;
         addr_ff    <= addr;
         qty_ff     <= qty;
         coil_ff    <= coil;
         rbc_ff     <= rbc;
         rlen_ff    <= rlen;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_command          = command_ff;
   assign rsp_function_code    = fc_ff;
   assign rsp_start_address    = addr_ff;
   assign rsp_quantity         = qty_ff;
   assign rsp_coil_on          = coil_ff;
   assign rsp_reply_byte_count = rbc_ff;
   assign rsp_reply_length     = rlen_ff;

   a_snap_to_rsp: assert property (@(posedge clock) disable iff (reset)
      snap_valid && snap_take |=> rsp_valid_ff)
      else $error("snapshot taken without a result beat");

   a_reject_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == ST_SHORT || status_ff == ST_OVERFLOW)
      |-> fc_ff == 8'h00 && qty_ff == 16'h0000 && rlen_ff == 9'd0)
      else $error("short or overflow result carries fields");

   a_write_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_ACCEPTED
      && (command_ff == CMD_WRITE_COIL || command_ff == CMD_WRITE_REGS)
      |-> rlen_ff == 9'd8)
      else $error("write reply length not 8");

endmodule

`default_nettype wire

@@ hdl/modbus_rtu_request_decoder_unit.sv @@
// Top level of the Modbus RTU request decoder: unit id register and stage wiring.
// Takes one frame byte per clock while req_stall is low (req_frame_end marks the last
// byte) and gives one result beat per frame; the last byte is registered into a snapshot,
// which then moves into the result register. Each byte updates the running CRC-16, header
// and byte count; the snapshot waits there until the result register can take it.
// req_stall rises only while a snapshot waits behind a stalled result register.
// csr_wr_en writes the unit id (reset value 1); write it only while no frame is pending.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_request_decoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_frame_end,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [1:0]       rsp_command,
   output logic [7:0]       rsp_function_code,
   output logic [15:0]      rsp_start_address,
   output logic [15:0]      rsp_quantity,
   output logic             rsp_coil_on,
   output logic [7:0]       rsp_reply_byte_count,
   output logic [8:0]       rsp_reply_length,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);
   import mrtu_pkg::*;

   logic [7:0] unit_id_ff, unit_id_in;
   logic       accept, snap_valid, snap_take;
   snap_type   snap;

   assign unit_id_in = csr_wr_en ? csr_wr_data : unit_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_id_ff <= UNIT_ID_RESET;
      end else begin
         unit_id_ff <= unit_id_in;
      end
   end

   assign req_stall = snap_valid && !snap_take;
   assign accept    = req_valid && !req_stall;

   mrtu_frame_acc u_frame_acc (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_rx_byte),
      .frame_end  (req_frame_end),
      .snap_take  (snap_take),
      .snap_valid (snap_valid),
      .snap       (snap)
   );

   mrtu_check u_check (
      .clock                (clock),
      .reset                (reset),
      .snap_valid           (snap_valid),
      .snap                 (snap),
      .unit_id              (unit_id_ff),
      .snap_take            (snap_take),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_command          (rsp_command),
      .rsp_function_code    (rsp_function_code),
      .rsp_start_address    (rsp_start_address),
      .rsp_quantity         (rsp_quantity),
      .rsp_coil_on          (rsp_coil_on),
      .rsp_reply_byte_count (rsp_reply_byte_count),
      .rsp_reply_length     (rsp_reply_length)
   );

endmodule

`default_nettype wire
